/* hw/rtl/phps_pkg.sv */
// Package for the polygon half-plane splitter.
// Holds widths, register indexes, step codes and the controller/datapath structs.
// No dependencies.
package phps_pkg;

  localparam int CW   = 32;
  localparam int FB   = 16;
  localparam int SW   = 2 * CW + 2;
  localparam int DW   = SW + 1;
  localparam int MW   = CW + 1;
  localparam int QW   = CW + 1;
  localparam int PW   = MW + SW;
  localparam int RW   = DW + 1;
  localparam int VW   = CW + 3;
  localparam int CNTW = $clog2(((MW > QW) ? MW : QW) + 1);
  localparam int IXW  = 3;

  localparam logic [IXW-1:0] REG_LINE_LEVEL   = 3'd0;
  localparam logic [IXW-1:0] REG_LEVEL_OFFSET = 3'd1;
  localparam logic [IXW-1:0] REG_COEF_Y_TERM  = 3'd2;
  localparam logic [IXW-1:0] REG_COEF_Z_TERM  = 3'd3;
  localparam logic [IXW-1:0] REG_PLUS_ENABLE  = 3'd4;
  localparam logic [IXW-1:0] REG_MINUS_ENABLE = 3'd5;

  localparam logic [2:0] STEP_V_FIRST   = 3'd0;
  localparam logic [2:0] STEP_X_FIRST   = 3'd1;
  localparam logic [2:0] STEP_V_PREV    = 3'd2;
  localparam logic [2:0] STEP_X_PREV    = 3'd3;
  localparam logic [2:0] STEP_V_CUR     = 3'd4;
  localparam logic [2:0] STEP_X_CLOSE   = 3'd5;

  localparam logic [1:0] SEEN_NONE  = 2'd0;
  localparam logic [1:0] SEEN_ONE   = 2'd1;
  localparam logic [1:0] SEEN_TWO   = 2'd2;
  localparam logic [1:0] SEEN_MANY  = 2'd3;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [SW-1:0] side_t;

  typedef struct packed {
    logic       cap;
    logic       mul1;
    logic       mul2;
    logic       sum;
    logic       xset;
    logic       xmul;
    logic       xdinit;
    logic       xdiv;
    logic       xfin;
    logic       axis;
    logic       load;
    logic       move;
    logic       last;
    logic       commit;
    logic [2:0] sel;
  } cmd_t;

  typedef struct packed {
    logic       emit_ok;
    logic       move_ok;
    logic       pend_v;
    logic       fin;
    logic       cnt_last;
    logic [1:0] seen;
  } sts_t;

endpackage

/* hw/rtl/phps_if.sv */
// Channel interfaces of the polygon half-plane splitter.
// Depends on phps_pkg for field types and widths.
interface phps_vertex_if;
  logic                  valid;
  logic                  ready;
  phps_pkg::coord_t      vertex_y;
  phps_pkg::coord_t      vertex_z;
  logic                  final_vertex;
  modport source (output valid, vertex_y, vertex_z, final_vertex, input ready);
  modport sink (input valid, vertex_y, vertex_z, final_vertex, output ready);
endinterface

interface phps_point_if;
  logic                  valid;
  logic                  ready;
  phps_pkg::coord_t      point_y;
  phps_pkg::coord_t      point_z;
  logic                  to_plus;
  logic                  to_minus;
  logic                  is_crossing;
  logic                  run_last;
  logic                  polygon_done;
  modport source (output valid, point_y, point_z, to_plus, to_minus, is_crossing,
                  run_last, polygon_done, input ready);
  modport sink (input valid, point_y, point_z, to_plus, to_minus, is_crossing,
                run_last, polygon_done, output ready);
endinterface

interface phps_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [phps_pkg::IXW-1:0]   index;
  logic [phps_pkg::CW-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/phps_ctrl.sv */
// Controller state machine of the polygon half-plane splitter.
// Depends on phps_pkg for the command and status structs.
module phps_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  phps_pkg::sts_t sts,
  output phps_pkg::cmd_t cmd
);
  import phps_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SIDE1  = 4'd1;
  localparam logic [3:0] ST_SIDE2  = 4'd2;
  localparam logic [3:0] ST_SIDE3  = 4'd3;
  localparam logic [3:0] ST_DISP   = 4'd4;
  localparam logic [3:0] ST_XSET   = 4'd5;
  localparam logic [3:0] ST_XMUL   = 4'd6;
  localparam logic [3:0] ST_XDINIT = 4'd7;
  localparam logic [3:0] ST_XDIV   = 4'd8;
  localparam logic [3:0] ST_XFIN   = 4'd9;
  localparam logic [3:0] ST_PUSH   = 4'd10;
  localparam logic [3:0] ST_FLUSH  = 4'd11;
  localparam logic [3:0] ST_COMMIT = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic [2:0] step_r, step_nxt;
  logic       axis_r, axis_nxt;
  logic [2:0] end_step;

  assign end_step = sts.fin ? STEP_X_CLOSE : STEP_V_CUR;
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    axis_nxt  = axis_r;
    cmd       = '0;
    cmd.sel   = step_r;
    cmd.axis  = axis_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = ST_SIDE1;
        end
      end
      ST_SIDE1: begin
        cmd.mul1  = 1'b1;
        state_nxt = ST_SIDE2;
      end
      ST_SIDE2: begin
        cmd.mul2  = 1'b1;
        state_nxt = ST_SIDE3;
      end
      ST_SIDE3: begin
        cmd.sum = 1'b1;
        if (sts.seen == SEEN_TWO) begin
          step_nxt  = STEP_V_FIRST;
          state_nxt = ST_DISP;
        end else if (sts.seen == SEEN_MANY) begin
          step_nxt  = STEP_X_PREV;
          state_nxt = ST_DISP;
        end else begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_DISP: begin
        if (step_r > end_step) begin
          state_nxt = ST_FLUSH;
        end else if (!sts.emit_ok) begin
          step_nxt = step_r + 3'd1;
        end else if (step_r[0]) begin
          axis_nxt  = 1'b0;
          state_nxt = ST_XSET;
        end else begin
          state_nxt = ST_PUSH;
        end
      end
      ST_XSET: begin
        cmd.xset  = 1'b1;
        state_nxt = ST_XMUL;
      end
      ST_XMUL: begin
        cmd.xmul = 1'b1;
        if (sts.cnt_last) begin
          state_nxt = ST_XDINIT;
        end
      end
      ST_XDINIT: begin
        cmd.xdinit = 1'b1;
        state_nxt  = ST_XDIV;
      end
      ST_XDIV: begin
        cmd.xdiv = 1'b1;
        if (sts.cnt_last) begin
          state_nxt = ST_XFIN;
        end
      end
      ST_XFIN: begin
        cmd.xfin = 1'b1;
        if (!axis_r) begin
          axis_nxt  = 1'b1;
          state_nxt = ST_XSET;
        end else begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!sts.pend_v || sts.move_ok) begin
          cmd.move  = sts.pend_v;
          cmd.load  = 1'b1;
          step_nxt  = step_r + 3'd1;
          state_nxt = ST_DISP;
        end
      end
      ST_FLUSH: begin
        if (!sts.pend_v) begin
          state_nxt = ST_COMMIT;
        end else if (sts.move_ok) begin
          cmd.move  = 1'b1;
          cmd.last  = 1'b1;
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= STEP_V_FIRST;
      axis_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      axis_r  <= axis_nxt;
    end
  end

  a_load_only_from_disp: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> $past(state_r) == ST_DISP || $past(state_r) == ST_XFIN
                 || $past(state_r) == ST_PUSH)
    else $error("pending result loaded out of sequence");
  a_xfin_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_XFIN |-> $past(state_r) == ST_XDIV)
    else $error("crossing finished without division");
  a_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !sts.pend_v)
    else $error("commit with a result still pending");

endmodule

/* hw/rtl/phps_dp.sv */
// Datapath of the polygon half-plane splitter: configuration, side values,
// shift-add multiplier, restoring divider and result registers. Depends on phps_pkg.
module phps_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  phps_pkg::cmd_t            cmd,
  output phps_pkg::sts_t            sts,
  input  logic                      cfg_we,
  input  logic [phps_pkg::IXW-1:0]  cfg_index,
  input  logic [phps_pkg::CW-1:0]   cfg_data,
  input  phps_pkg::coord_t          in_y,
  input  phps_pkg::coord_t          in_z,
  input  logic                      in_fin,
  output logic                      out_valid,
  input  logic                      out_ready,
  output phps_pkg::coord_t          out_y,
  output phps_pkg::coord_t          out_z,
  output logic                      out_plus,
  output logic                      out_minus,
  output logic                      out_cross,
  output logic                      out_last,
  output logic                      out_done
);
  import phps_pkg::*;

  coord_t line_level_r, level_offset_r, coef_y_r, coef_z_r;
  logic   plus_en_r, minus_en_r;

  coord_t cur_y_r, cur_z_r, first_y_r, first_z_r, prev_y_r, prev_z_r;
  side_t  cur_s_r, first_s_r, prev_s_r;
  logic   fin_r;
  logic [1:0] seen_r;

  logic signed [2*CW-1:0] prod_a_r, prod_b_r;
  logic signed [CW:0]     lvl;
  side_t                  lsh;

  coord_t e0_y, e0_z, e1_y, e1_z, v_y, v_z;
  side_t  e0_s, e1_s, v_s;
  logic   v_neg, v_zero, n0, p0, n1, p1, v_plus, v_minus, x_ok;

  coord_t                  c0, c1;
  logic signed [MW-1:0]    dy;
  logic [MW-1:0]           dy_mag;
  logic [SW-1:0]           s0_mag;
  logic signed [DW-1:0]    dd;
  logic [DW-1:0]           d_mag;

  logic [MW-1:0]    mb_r;
  logic [PW-1:0]    mc_r, acc_r;
  logic [DW-1:0]    dmag_r;
  logic             negq_r;
  coord_t           c0_r;
  logic [CNTW-1:0]  cnt_r;
  logic [RW-1:0]    rem_r, trial;
  logic [QW-1:0]    q_r;
  logic             qbit;
  logic signed [QW:0] qs;
  logic signed [VW-1:0] vsum;
  coord_t           sat;
  coord_t           cross_y_r, cross_z_r;

  coord_t pend_y_r, pend_z_r;
  logic   pend_v_r, pend_p_r, pend_m_r, pend_x_r;
  logic   ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_level_r   <= '0;
      level_offset_r <= '0;
      coef_y_r       <= '0;
      coef_z_r       <= '0;
      plus_en_r      <= 1'b1;
      minus_en_r     <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LINE_LEVEL:   line_level_r   <= cfg_data;
        REG_LEVEL_OFFSET: level_offset_r <= cfg_data;
        REG_COEF_Y_TERM:  coef_y_r       <= cfg_data;
        REG_COEF_Z_TERM:  coef_z_r       <= cfg_data;
        REG_PLUS_ENABLE:  plus_en_r      <= cfg_data[0];
        REG_MINUS_ENABLE: minus_en_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign lvl = {line_level_r[CW-1], line_level_r} - {level_offset_r[CW-1], level_offset_r};
  assign lsh = side_t'(lvl) <<< FB;

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      cur_y_r <= in_y;
      cur_z_r <= in_z;
      fin_r   <= in_fin;
    end
    if (cmd.mul1) begin
      prod_a_r <= coef_z_r * cur_y_r;
    end
    if (cmd.mul2) begin
      prod_b_r <= coef_y_r * cur_z_r;
    end
    if (cmd.sum) begin
      cur_s_r <= lsh + side_t'(prod_a_r) + side_t'(prod_b_r);
    end
    if (cmd.commit) begin
      if (seen_r == SEEN_NONE) begin
        first_y_r <= cur_y_r;
        first_z_r <= cur_z_r;
        first_s_r <= cur_s_r;
      end
      prev_y_r <= cur_y_r;
      prev_z_r <= cur_z_r;
      prev_s_r <= cur_s_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= SEEN_NONE;
    end else if (cmd.commit) begin
      if (fin_r) begin
        seen_r <= SEEN_NONE;
      end else if (seen_r != SEEN_MANY) begin
        seen_r <= seen_r + 2'd1;
      end
    end
  end

  always_comb begin
    case (cmd.sel)
      STEP_X_FIRST: begin
        e0_y = first_y_r; e0_z = first_z_r; e0_s = first_s_r;
        e1_y = prev_y_r;  e1_z = prev_z_r;  e1_s = prev_s_r;
      end
      STEP_X_PREV: begin
        e0_y = prev_y_r; e0_z = prev_z_r; e0_s = prev_s_r;
        e1_y = cur_y_r;  e1_z = cur_z_r;  e1_s = cur_s_r;
      end
      default: begin
        e0_y = cur_y_r;   e0_z = cur_z_r;   e0_s = cur_s_r;
        e1_y = first_y_r; e1_z = first_z_r; e1_s = first_s_r;
      end
    endcase
    case (cmd.sel)
      STEP_V_FIRST: begin
        v_y = first_y_r; v_z = first_z_r; v_s = first_s_r;
      end
      STEP_V_PREV: begin
        v_y = prev_y_r; v_z = prev_z_r; v_s = prev_s_r;
      end
      default: begin
        v_y = cur_y_r; v_z = cur_z_r; v_s = cur_s_r;
      end
    endcase
  end

  assign v_neg   = v_s[SW-1];
  assign v_zero  = (v_s == '0);
  assign v_plus  = plus_en_r && !v_neg;
  assign v_minus = minus_en_r && (v_neg || v_zero);
  assign n0      = e0_s[SW-1];
  assign p0      = !e0_s[SW-1] && (e0_s != '0);
  assign n1      = e1_s[SW-1];
  assign p1      = !e1_s[SW-1] && (e1_s != '0);
  assign x_ok    = (plus_en_r || minus_en_r) && ((n0 && p1) || (p0 && n1));

  assign c0     = cmd.axis ? e0_z : e0_y;
  assign c1     = cmd.axis ? e1_z : e1_y;
  assign dy     = {c1[CW-1], c1} - {c0[CW-1], c0};
  assign dy_mag = dy[MW-1] ? MW'(-dy) : MW'(dy);
  assign s0_mag = e0_s[SW-1] ? SW'(-e0_s) : SW'(e0_s);
  assign dd     = DW'(e0_s) - DW'(e1_s);
  assign d_mag  = dd[DW-1] ? DW'(-dd) : DW'(dd);

  assign trial = {rem_r[RW-2:0], q_r[QW-1]};
  assign qbit  = (trial >= RW'(dmag_r));
  assign qs    = negq_r ? (-$signed({1'b0, q_r}) - $signed((QW+1)'(rem_r != '0)))
                        : $signed({1'b0, q_r});
  assign vsum  = VW'(c0_r) + VW'(qs);

  always_comb begin
    if (vsum > VW'(coord_t'({1'b0, {(CW-1){1'b1}}}))) begin
      sat = {1'b0, {(CW-1){1'b1}}};
    end else if (vsum < VW'(coord_t'({1'b1, {(CW-1){1'b0}}}))) begin
      sat = {1'b1, {(CW-1){1'b0}}};
    end else begin
      sat = vsum[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.xset) begin
      cnt_r <= CNTW'(MW);
    end else if (cmd.xdinit) begin
      cnt_r <= CNTW'(QW);
    end else if (cmd.xmul || cmd.xdiv) begin
      cnt_r <= cnt_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.xset) begin
      mb_r   <= dy_mag;
      mc_r   <= PW'(s0_mag);
      acc_r  <= '0;
      dmag_r <= d_mag;
      negq_r <= dy[MW-1] ^ e0_s[SW-1] ^ dd[DW-1];
      c0_r   <= c0;
    end
    if (cmd.xmul) begin
      if (mb_r[0]) begin
        acc_r <= acc_r + mc_r;
      end
      mc_r <= mc_r << 1;
      mb_r <= mb_r >> 1;
    end
    if (cmd.xdinit) begin
      rem_r <= RW'(acc_r[PW-1:QW]);
      q_r   <= acc_r[QW-1:0];
    end
    if (cmd.xdiv) begin
      rem_r <= qbit ? (trial - RW'(dmag_r)) : trial;
      q_r   <= {q_r[QW-2:0], qbit};
    end
    if (cmd.xfin) begin
      if (cmd.axis) begin
        cross_z_r <= sat;
      end else begin
        cross_y_r <= sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (cmd.sel[0]) begin
        pend_y_r <= cross_y_r;
        pend_z_r <= cross_z_r;
        pend_p_r <= plus_en_r;
        pend_m_r <= minus_en_r;
        pend_x_r <= 1'b1;
      end else begin
        pend_y_r <= v_y;
        pend_z_r <= v_z;
        pend_p_r <= v_plus;
        pend_m_r <= v_minus;
        pend_x_r <= 1'b0;
      end
    end
    if (cmd.move) begin
      out_y     <= pend_y_r;
      out_z     <= pend_z_r;
      out_plus  <= pend_p_r;
      out_minus <= pend_m_r;
      out_cross <= pend_x_r;
      out_last  <= cmd.last;
      out_done  <= cmd.last && fin_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      if (cmd.load) begin
        pend_v_r <= 1'b1;
      end else if (cmd.move) begin
        pend_v_r <= 1'b0;
      end
      if (cmd.move) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign out_valid    = ov_r;
  assign sts.emit_ok  = cmd.sel[0] ? x_ok : (v_plus || v_minus);
  assign sts.move_ok  = !ov_r || out_ready;
  assign sts.pend_v   = pend_v_r;
  assign sts.fin      = fin_r;
  assign sts.cnt_last = (cnt_r == CNTW'(1));
  assign sts.seen     = seen_r;

  a_move_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.move |-> sts.move_ok)
    else $error("result moved into a full output register");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load && pend_v_r |-> cmd.move)
    else $error("pending result overwritten");
  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.xdiv |-> cnt_r != '0)
    else $error("divider ran past its count");
  a_move_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.move |=> ov_r)
    else $error("moved result not presented");

endmodule

/* hw/rtl/polygon_half_plane_split_top.sv */
// Top level of the polygon half-plane splitter.
// Depends on phps_pkg, the channel interfaces, phps_ctrl and phps_dp.
//
//   Channel   Direction  Carries
//   in_vtx    sink       vertex_y, vertex_z, final_vertex
//   out_pt    source     point_y, point_z, to_plus, to_minus, is_crossing, run_last,
//                        polygon_done
//   cfg_wr    sink       index, data (always ready)
//
// A vertex that produces no results for its polygon yet passes through capture, the two
// side products, the sum and commit. From the third vertex on, each output step is
// examined, the run is finished, each result is loaded, and each crossing takes two
// shift-add multiply and divide passes, one per axis. A result that waits for the output
// register to be taken stalls the run until the register is free.
// Reset is synchronous and active low; the data registers are loaded before they are used.
// A stalled output holds its transaction; the next vertex is taken once the current
// one has handed its last result to the output register.
module polygon_half_plane_split_top (
  input logic        clk,
  input logic        rst_n,
  phps_vertex_if.sink  in_vtx,
  phps_point_if.source out_pt,
  phps_cfg_if.sink     cfg_wr
);
  import phps_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_wr.ready = 1'b1;

  phps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_vtx.valid),
    .in_ready (in_vtx.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  phps_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_wr.valid),
    .cfg_index (cfg_wr.index),
    .cfg_data  (cfg_wr.data),
    .in_y      (in_vtx.vertex_y),
    .in_z      (in_vtx.vertex_z),
    .in_fin    (in_vtx.final_vertex),
    .out_valid (out_pt.valid),
    .out_ready (out_pt.ready),
    .out_y     (out_pt.point_y),
    .out_z     (out_pt.point_z),
    .out_plus  (out_pt.to_plus),
    .out_minus (out_pt.to_minus),
    .out_cross (out_pt.is_crossing),
    .out_last  (out_pt.run_last),
    .out_done  (out_pt.polygon_done)
  );

endmodule

/* bench/polygon_half_plane_split_top_tb.sv */
// Self-checking testbench for the polygon half-plane splitter, driving vertices,
// predicting every emitted point and crossing, and comparing it field by field.
// Depends on phps_pkg, the channel interfaces and polygon_half_plane_split_top.
module polygon_half_plane_split_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import phps_pkg::*;

  localparam int SETTLE_CYCLES = 1000;
  localparam int CYCLE_LIMIT   = 3000000;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    coord_t y;
    coord_t z;
    logic   fin;
    logic   hold;
  } vertex_t;

  typedef struct {
    coord_t y;
    coord_t z;
    logic   to_plus;
    logic   to_minus;
    logic   is_crossing;
    logic   run_last;
    logic   polygon_done;
  } point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  phps_vertex_if in_vtx();
  phps_point_if  out_pt();
  phps_cfg_if    cfg_wr();

  polygon_half_plane_split_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vtx (in_vtx),
    .out_pt (out_pt),
    .cfg_wr (cfg_wr)
  );

  always #1 clk = ~clk;

  vertex_t pending_vertices[$];
  point_t  expected_points[$];
  point_t  step_points[$];

  logic signed [31:0] cur_level, cur_offset, cur_coef_y, cur_coef_z;
  logic               cur_plus, cur_minus;

  coord_t first_y, first_z, second_y, second_z, prev_y, prev_z;
  wide_t  first_side, prev_side;
  logic [1:0] seen;

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int errors          = 0;
  int vertices_taken  = 0;
  int points_checked  = 0;
  int crossings_seen  = 0;
  int cycles          = 0;

  function automatic wide_t side_of(coord_t y, coord_t z);
    wide_t l;
    wide_t a;
    wide_t b;
    l = wide_t'(cur_level) - wide_t'(cur_offset);
    a = wide_t'(cur_coef_z) * wide_t'(y);
    b = wide_t'(cur_coef_y) * wide_t'(z);
    return (l <<< FB) + a + b;
  endfunction

  function automatic void add_point(coord_t y, coord_t z, logic p, logic m, logic c);
    point_t pt;
    if (!p && !m) return;
    pt.y = y;
    pt.z = z;
    pt.to_plus = p;
    pt.to_minus = m;
    pt.is_crossing = c;
    pt.run_last = 1'b0;
    pt.polygon_done = 1'b0;
    step_points.push_back(pt);
  endfunction

  function automatic void add_vertex_point(coord_t y, coord_t z, wide_t s);
    add_point(y, z, cur_plus && s >= 0, cur_minus && s <= 0, 1'b0);
  endfunction

  function automatic coord_t crossing_coord(coord_t a0, coord_t a1, wide_t s0, wide_t d);
    wide_t num;
    wide_t q;
    wide_t r;
    wide_t v;
    num = (wide_t'(a1) - wide_t'(a0)) * s0;
    q = num / d;
    r = num % d;
    if (r != 0 && ((num < 0) != (d < 0))) q = q - 1;
    v = wide_t'(a0) + q;
    if (v > wide_t'(32'sh7fffffff)) return 32'sh7fffffff;
    if (v < -wide_t'(64'sh80000000)) return 32'sh80000000;
    return coord_t'(v);
  endfunction

  function automatic void add_crossing(coord_t y0, coord_t z0, wide_t s0,
                                       coord_t y1, coord_t z1, wide_t s1);
    wide_t d;
    if (!((s0 > 0 && s1 < 0) || (s0 < 0 && s1 > 0))) return;
    d = s0 - s1;
    if (d == 0) return;
    add_point(crossing_coord(y0, y1, s0, d), crossing_coord(z0, z1, s0, d),
              cur_plus, cur_minus, 1'b1);
  endfunction

  function automatic void predict_split(vertex_t v);
    wide_t s;
    s = side_of(v.y, v.z);
    step_points.delete();
    case (seen)
      SEEN_NONE: begin
        first_y = v.y;
        first_z = v.z;
        first_side = s;
        seen = v.fin ? SEEN_NONE : SEEN_ONE;
      end
      SEEN_ONE: begin
        second_y = v.y;
        second_z = v.z;
        seen = v.fin ? SEEN_NONE : SEEN_TWO;
      end
      SEEN_TWO: begin
        add_vertex_point(first_y, first_z, first_side);
        add_crossing(first_y, first_z, first_side, second_y, second_z, prev_side);
        add_vertex_point(second_y, second_z, prev_side);
        add_crossing(second_y, second_z, prev_side, v.y, v.z, s);
        add_vertex_point(v.y, v.z, s);
        if (v.fin) add_crossing(v.y, v.z, s, first_y, first_z, first_side);
        seen = v.fin ? SEEN_NONE : SEEN_MANY;
      end
      default: begin
        add_crossing(prev_y, prev_z, prev_side, v.y, v.z, s);
        add_vertex_point(v.y, v.z, s);
        if (v.fin) add_crossing(v.y, v.z, s, first_y, first_z, first_side);
        seen = v.fin ? SEEN_NONE : SEEN_MANY;
      end
    endcase
    prev_y = v.y;
    prev_z = v.z;
    prev_side = s;
    if (step_points.size() > 0) begin
      step_points[step_points.size()-1].run_last = 1'b1;
      step_points[step_points.size()-1].polygon_done = v.fin;
    end
    foreach (step_points[i]) expected_points.push_back(step_points[i]);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_vtx.valid <= 1'b0;
    end else begin
      if (in_vtx.valid && in_vtx.ready) begin
        predict_split(pending_vertices.pop_front());
        vertices_taken++;
      end
      if (!in_vtx.valid || in_vtx.ready) begin
        if (pending_vertices.size() > 0 && $urandom_range(99) >= sender_idle_pct &&
            !(pending_vertices[0].hold && expected_points.size() > 0)) begin
          in_vtx.valid <= 1'b1;
          in_vtx.vertex_y <= pending_vertices[0].y;
          in_vtx.vertex_z <= pending_vertices[0].z;
          in_vtx.final_vertex <= pending_vertices[0].fin;
        end else begin
          in_vtx.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    point_t exp_pt;
    if (!rst_n) begin
      out_pt.ready <= 1'b0;
    end else begin
      if (out_pt.valid && out_pt.ready) begin
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected point y=%h z=%h", $time, out_pt.point_y, out_pt.point_z);
          errors++;
        end else begin
          exp_pt = expected_points.pop_front();
          points_checked++;
          if (exp_pt.is_crossing) crossings_seen++;
          if (out_pt.point_y !== exp_pt.y || out_pt.point_z !== exp_pt.z ||
              out_pt.to_plus !== exp_pt.to_plus || out_pt.to_minus !== exp_pt.to_minus ||
              out_pt.is_crossing !== exp_pt.is_crossing ||
              out_pt.run_last !== exp_pt.run_last ||
              out_pt.polygon_done !== exp_pt.polygon_done) begin
            $display("%0t: expected y=%h z=%h p=%b m=%b x=%b last=%b done=%b", $time,
                     exp_pt.y, exp_pt.z, exp_pt.to_plus, exp_pt.to_minus,
                     exp_pt.is_crossing, exp_pt.run_last, exp_pt.polygon_done);
            $display("%0t: actual   y=%h z=%h p=%b m=%b x=%b last=%b done=%b", $time,
                     out_pt.point_y, out_pt.point_z, out_pt.to_plus, out_pt.to_minus,
                     out_pt.is_crossing, out_pt.run_last, out_pt.polygon_done);
            errors++;
          end
        end
      end
      out_pt.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(logic [IXW-1:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= idx;
    cfg_wr.data <= data;
    do @(posedge clk); while (!cfg_wr.ready);
    cfg_wr.valid <= 1'b0;
    case (idx)
      REG_LINE_LEVEL:   cur_level = data;
      REG_LEVEL_OFFSET: cur_offset = data;
      REG_COEF_Y_TERM:  cur_coef_y = data;
      REG_COEF_Z_TERM:  cur_coef_z = data;
      REG_PLUS_ENABLE:  cur_plus = data[0];
      default:          cur_minus = data[0];
    endcase
  endtask

  task automatic set_line(logic [31:0] lvl, logic [31:0] ofs, logic [31:0] cy,
                          logic [31:0] cz, logic p, logic m);
    write_reg(REG_LINE_LEVEL, lvl);
    write_reg(REG_LEVEL_OFFSET, ofs);
    write_reg(REG_COEF_Y_TERM, cy);
    write_reg(REG_COEF_Z_TERM, cz);
    write_reg(REG_PLUS_ENABLE, {31'd0, p});
    write_reg(REG_MINUS_ENABLE, {31'd0, m});
  endtask

  task automatic queue_vertex(coord_t y, coord_t z, logic fin, logic hold);
    vertex_t v;
    v.y = y;
    v.z = z;
    v.fin = fin;
    v.hold = hold;
    pending_vertices.push_back(v);
  endtask

  function automatic coord_t rand_coord(bit full);
    if (full) return $urandom;
    return coord_t'($urandom_range(0, 4194304)) - 32'sd2097152;
  endfunction

  function automatic logic [31:0] rand_coef(int kind);
    if (kind == 0) return $urandom;
    return 32'($urandom_range(0, 262144)) - 32'd131072;
  endfunction

  task automatic queue_polygon(int n, bit full, logic hold);
    for (int k = 0; k < n; k++)
      queue_vertex(rand_coord(full), rand_coord(full), k == n - 1, hold && k == 0);
  endtask

  task automatic drain();
    while (pending_vertices.size() > 0 || in_vtx.valid) @(posedge clk);
    while (expected_points.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int n;
    int budget;
    in_vtx.valid = 1'b0;
    in_vtx.vertex_y = '0;
    in_vtx.vertex_z = '0;
    in_vtx.final_vertex = 1'b0;
    out_pt.ready = 1'b0;
    cfg_wr.valid = 1'b0;
    cfg_wr.index = '0;
    cfg_wr.data = '0;
    cur_level = 0;
    cur_offset = 0;
    cur_coef_y = 0;
    cur_coef_z = 0;
    cur_plus = 1'b1;
    cur_minus = 1'b1;
    first_y = 0;
    first_z = 0;
    second_y = 0;
    second_z = 0;
    prev_y = 0;
    prev_z = 0;
    first_side = 0;
    prev_side = 0;
    seen = SEEN_NONE;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    queue_vertex(32'sh7fffffff, 32'sh80000000, 1'b0, 1'b0);
    queue_vertex(32'sh80000000, 32'sh7fffffff, 1'b0, 1'b0);
    queue_vertex(32'sh00000000, 32'shffffffff, 1'b1, 1'b0);
    queue_vertex(32'sh00010000, 32'sh00020000, 1'b1, 1'b0);
    queue_vertex(32'sh00010000, 32'sh00020000, 1'b0, 1'b0);
    queue_vertex(32'sh00030000, 32'sh00040000, 1'b1, 1'b0);
    drain();

    set_line(32'h0, 32'h0, 32'h0, 32'h0001_0000, 1'b1, 1'b1);
    queue_vertex(-32'sh00020000, -32'sh00010000, 1'b0, 1'b0);
    queue_vertex(32'sh00020000, -32'sh00010000, 1'b0, 1'b0);
    queue_vertex(32'sh00000000, 32'sh00030000, 1'b0, 1'b0);
    queue_vertex(32'sh00030000, 32'sh00050000, 1'b0, 1'b0);
    queue_vertex(-32'sh00030000, 32'sh00050000, 1'b1, 1'b0);
    queue_vertex(32'sh7fffffff, 32'sh7fffffff, 1'b0, 1'b0);
    queue_vertex(32'sh80000000, 32'sh80000000, 1'b0, 1'b0);
    queue_vertex(32'sh00000001, 32'sh7fffffff, 1'b0, 1'b0);
    queue_vertex(32'sh80000000, 32'sh00000001, 1'b1, 1'b1);
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin sender_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      case (p)
        3: set_line(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 1'b1, 1'b1);
        4: set_line(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 1'b1, 1'b1);
        5: set_line(rand_coef(1), rand_coef(1), rand_coef(1), rand_coef(1), 1'b0, 1'b1);
        6: set_line(rand_coef(1), rand_coef(1), rand_coef(1), rand_coef(1), 1'b1, 1'b0);
        7: set_line(rand_coef(1), rand_coef(1), rand_coef(1), rand_coef(1), 1'b0, 1'b0);
        default: set_line(rand_coef(1), rand_coef(1), rand_coef(p % 2), rand_coef(1),
                          1'b1, 1'b1);
      endcase
      budget = (p == 7) ? 15 : 48;
      while (budget > 0) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 7);
        queue_polygon(n, $urandom_range(3) == 0, $urandom_range(7) == 0);
        budget -= n;
      end
      drain();
    end
    set_line(32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b1);
    drain();

    $display("Covered %0d vertices and %0d points, %0d of them crossings,",
             vertices_taken, points_checked, crossings_seen);
    $display("across extreme and random cutting lines, enable settings and stall patterns.");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

/* sim.f */
hw/rtl/phps_pkg.sv
hw/rtl/phps_if.sv
hw/rtl/phps_ctrl.sv
hw/rtl/phps_dp.sv
hw/rtl/polygon_half_plane_split_top.sv
bench/polygon_half_plane_split_top_tb.sv
